FILE: design/ftok_pkg.sv
// Shared token codes, trie tables and result record for the formula tokenizer.
`timescale 1ns / 1ps

package ftok_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int FIELD_W          = 16;
    localparam int KIND_W           = 5;
    localparam int NODE_W           = 5;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [NODE_W-1:0] t_node;

    // Token kinds.
    localparam t_kind KIND_PLUS   = 5'd0;
    localparam t_kind KIND_MINUS  = 5'd1;
    localparam t_kind KIND_STAR   = 5'd2;
    localparam t_kind KIND_SLASH  = 5'd3;
    localparam t_kind KIND_LPAREN = 5'd4;
    localparam t_kind KIND_RPAREN = 5'd5;
    localparam t_kind KIND_SEMI   = 5'd6;
    localparam t_kind KIND_COLON  = 5'd7;
    localparam t_kind KIND_SQRT   = 5'd8;
    localparam t_kind KIND_SUM    = 5'd9;
    localparam t_kind KIND_AVG    = 5'd10;
    localparam t_kind KIND_MIN    = 5'd11;
    localparam t_kind KIND_MAX    = 5'd12;
    localparam t_kind KIND_POW    = 5'd13;
    localparam t_kind KIND_NUMBER = 5'd14;
    localparam t_kind KIND_CELL   = 5'd15;
    localparam t_kind KIND_ERROR  = 5'd16;
    localparam t_kind KIND_NONE   = 5'd31;

    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam t_node NODE_ROOT = 5'd0;

    // One result record as it waits in the output queue.
    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] start_pos;
        logic [FIELD_W-1:0] end_pos;
        logic [FIELD_W-1:0] literal_index;
        logic               run_last;
        logic               formula_done;
    } t_token;

    // Child of a trie node carrying character c, or the root when there is none.
    function automatic t_node trie_child(input t_node node, input logic [7:0] c);
        t_node ch;
        ch = NODE_ROOT;
        case (node)
            5'd0: begin
                case (c)
                    "+":     ch = 5'd1;
                    "-":     ch = 5'd2;
                    "*":     ch = 5'd3;
                    "/":     ch = 5'd4;
                    "(":     ch = 5'd5;
                    ")":     ch = 5'd6;
                    ";":     ch = 5'd7;
                    ":":     ch = 5'd8;
                    "S":     ch = 5'd9;
                    "A":     ch = 5'd15;
                    "M":     ch = 5'd18;
                    "P":     ch = 5'd23;
                    default: ch = NODE_ROOT;
                endcase
            end
            5'd9: begin
                if (c == "Q") begin
                    ch = 5'd10;
                end else if (c == "U") begin
                    ch = 5'd13;
                end
            end
            5'd10:   ch = (c == "R") ? 5'd11 : NODE_ROOT;
            5'd11:   ch = (c == "T") ? 5'd12 : NODE_ROOT;
            5'd13:   ch = (c == "M") ? 5'd14 : NODE_ROOT;
            5'd15:   ch = (c == "V") ? 5'd16 : NODE_ROOT;
            5'd16:   ch = (c == "G") ? 5'd17 : NODE_ROOT;
            5'd18: begin
                if (c == "I") begin
                    ch = 5'd19;
                end else if (c == "A") begin
                    ch = 5'd21;
                end
            end
            5'd19:   ch = (c == "N") ? 5'd20 : NODE_ROOT;
            5'd21:   ch = (c == "X") ? 5'd22 : NODE_ROOT;
            5'd23:   ch = (c == "O") ? 5'd24 : NODE_ROOT;
            5'd24:   ch = (c == "W") ? 5'd25 : NODE_ROOT;
            default: ch = NODE_ROOT;
        endcase
        return ch;
    endfunction

    // Token kind completed at a trie node, KIND_NONE for inner nodes.
    function automatic t_kind node_kind(input t_node node);
        t_kind k;
        case (node)
            5'd1:    k = KIND_PLUS;
            5'd2:    k = KIND_MINUS;
            5'd3:    k = KIND_STAR;
            5'd4:    k = KIND_SLASH;
            5'd5:    k = KIND_LPAREN;
            5'd6:    k = KIND_RPAREN;
            5'd7:    k = KIND_SEMI;
            5'd8:    k = KIND_COLON;
            5'd12:   k = KIND_SQRT;
            5'd14:   k = KIND_SUM;
            5'd17:   k = KIND_AVG;
            5'd20:   k = KIND_MIN;
            5'd22:   k = KIND_MAX;
            5'd25:   k = KIND_POW;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: design/formula_tokenizer.sv
// Streaming spreadsheet formula tokenizer: one character in, zero to two tokens out.
`timescale 1ns / 1ps

//  Channel   Direction  Item                          tdata / tuser / tlast
//  -------   ---------  ----------------------------  ----------------------------------------
//  s (in)    slave      one formula character         tdata[7:0] text_byte, tlast final_byte
//  m (out)   master     one token                     tdata start/end/literal_index,
//                                                      tuser token_kind/formula_done,
//                                                      tlast run_last
//
// Each character is lexed in the cycle it is accepted: the scanner state and the tokens it
// causes are computed by one pass of short logic and land in registers at that edge.
// Tokens wait in a four-entry output queue, so a character is accepted every cycle while
// the queue has room for two tokens; a character that closes one token and opens another
// takes two queue entries. The first token of an item shows in the cycle after acceptance.
// Reset (synchronous, active low) empties the queue and returns the scanner to waiting for
// the leading '=' of a new formula. A stall on the output only holds the input back once
// the queue is down to fewer than two free entries.

module formula_tokenizer
    import ftok_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input characters.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // final_byte
    // Output tokens.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] start_pos, [31:16] end_pos,
                                     // [47:32] literal_index
    output logic [7:0]  o_m_tuser,   // [4:0] token_kind, [5] formula_done, [7:6] zero
    output logic        o_m_tlast    // run_last
);

    typedef enum logic [3:0] {
        MODE_FIRST,
        MODE_REJECT,
        MODE_GAP,
        MODE_TRIE,
        MODE_LETTERS,
        MODE_DIGITS,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC
    } t_mode;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [FIELD_W-1:0]  CNT_MAX = {FIELD_W{1'b1}};

    // Scanner state.
    t_mode               r_mode,   n_mode;
    t_node               r_node,   n_node;
    logic [POS_BITS-1:0] r_tstart, n_tstart;
    logic [POS_BITS-1:0] r_pos,    n_pos;
    logic [FIELD_W-1:0]  r_ncnt,   n_ncnt;
    logic [FIELD_W-1:0]  r_ccnt,   n_ccnt;

    // Output queue.
    t_token     r_fifo [4];
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [2:0] r_count,  n_count;

    logic       in_fire;
    logic       out_fire;
    logic [7:0] c;
    logic       is_letter, is_digit, is_space;
    logic [POS_BITS-1:0] end1;
    logic       consumed;
    t_node      child;
    t_node      root_ch;

    // Up to three candidate tokens per character: closing a pending token, a one-character
    // token started by this character, and the flush at the end of the formula.
    logic                a_vld, b_vld, f_vld;
    t_kind               a_kind, b_kind, f_kind;
    logic [POS_BITS-1:0] a_start, a_end, f_start;
    logic [FIELD_W-1:0]  a_lit, f_lit;
    t_mode               mode_a;
    t_node               node_a;
    logic [FIELD_W-1:0]  ncnt_a, ccnt_a;

    t_token     tok0, tok1, tok_a, tok_b, tok_f;
    logic [1:0] wr_n;

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_count <= 3'd2);
    assign o_m_tvalid = (r_count != 3'd0);

    always_comb begin
        c = i_s_tdata;
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32;
        end
    end

    assign is_letter = (c >= "A") && (c <= "Z");
    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_space  = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign end1      = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
    assign child     = is_letter ? trie_child(r_node, c) : NODE_ROOT;
    assign root_ch   = trie_child(NODE_ROOT, c);

    // Scanner step.
    always_comb begin
        mode_a   = r_mode;
        node_a   = r_node;
        consumed = 1'b1;
        a_vld    = 1'b0;
        a_kind   = KIND_ERROR;
        a_start  = r_tstart;
        a_end    = r_pos;
        a_lit    = '0;
        ncnt_a   = r_ncnt;
        ccnt_a   = r_ccnt;

        case (r_mode)
            MODE_FIRST: begin
                mode_a = (c == CHAR_EQ) ? MODE_GAP : MODE_REJECT;
            end
            MODE_REJECT: begin
                mode_a = MODE_REJECT;
            end
            MODE_TRIE: begin
                if (child != NODE_ROOT) begin
                    node_a = child;
                    if (node_kind(child) != KIND_NONE) begin
                        a_vld  = 1'b1;
                        a_kind = node_kind(child);
                        a_end  = end1;
                        mode_a = MODE_GAP;
                    end
                end else if (is_letter) begin
                    mode_a = MODE_LETTERS;
                end else if (is_digit) begin
                    mode_a = MODE_DIGITS;
                end else begin
                    a_vld    = 1'b1;
                    mode_a   = MODE_GAP;
                    consumed = 1'b0;
                end
            end
            MODE_LETTERS: begin
                if (is_digit) begin
                    mode_a = MODE_DIGITS;
                end else if (!is_letter) begin
                    a_vld    = 1'b1;
                    mode_a   = MODE_GAP;
                    consumed = 1'b0;
                end
            end
            MODE_DIGITS: begin
                if (!is_digit) begin
                    a_vld    = 1'b1;
                    a_kind   = KIND_CELL;
                    a_lit    = r_ccnt;
                    ccnt_a   = (r_ccnt == CNT_MAX) ? CNT_MAX : r_ccnt + 1'b1;
                    mode_a   = MODE_GAP;
                    consumed = 1'b0;
                end
            end
            MODE_INT, MODE_FRAC: begin
                if (r_mode == MODE_INT && c == CHAR_DOT) begin
                    mode_a = MODE_DOT;
                end else if (!is_digit) begin
                    a_vld    = 1'b1;
                    a_kind   = KIND_NUMBER;
                    a_lit    = r_ncnt;
                    ncnt_a   = (r_ncnt == CNT_MAX) ? CNT_MAX : r_ncnt + 1'b1;
                    mode_a   = MODE_GAP;
                    consumed = 1'b0;
                end
            end
            MODE_DOT: begin
                if (is_digit) begin
                    mode_a = MODE_FRAC;
                end else begin
                    a_vld    = 1'b1;
                    mode_a   = MODE_GAP;
                    consumed = 1'b0;
                end
            end
            default: begin
                mode_a   = MODE_GAP;
                consumed = 1'b0;
            end
        endcase

        // A character not taken by the pending token opens a new one unless it is whitespace.
        n_mode   = mode_a;
        n_node   = node_a;
        n_tstart = r_tstart;
        b_vld    = 1'b0;
        b_kind   = KIND_ERROR;
        if (!consumed && !is_space) begin
            n_tstart = r_pos;
            if (is_letter) begin
                n_node = root_ch;
                n_mode = (root_ch != NODE_ROOT) ? MODE_TRIE : MODE_LETTERS;
            end else if (is_digit) begin
                n_mode = MODE_INT;
            end else begin
                b_vld = 1'b1;
                if (root_ch != NODE_ROOT && node_kind(root_ch) != KIND_NONE) begin
                    b_kind = node_kind(root_ch);
                end
            end
        end

        // Final character: close whatever is pending and start the next formula afresh.
        n_ncnt  = ncnt_a;
        n_ccnt  = ccnt_a;
        n_pos   = end1;
        f_vld   = 1'b0;
        f_kind  = KIND_ERROR;
        f_start = n_tstart;
        f_lit   = '0;
        if (i_s_tlast) begin
            case (n_mode)
                MODE_TRIE, MODE_LETTERS, MODE_DOT: begin
                    f_vld = 1'b1;
                end
                MODE_DIGITS: begin
                    f_vld  = 1'b1;
                    f_kind = KIND_CELL;
                    f_lit  = ccnt_a;
                end
                MODE_INT, MODE_FRAC: begin
                    f_vld  = 1'b1;
                    f_kind = KIND_NUMBER;
                    f_lit  = ncnt_a;
                end
                default: begin
                    f_vld = 1'b0;
                end
            endcase
            n_mode   = MODE_FIRST;
            n_node   = NODE_ROOT;
            n_tstart = '0;
            n_pos    = '0;
            n_ncnt   = '0;
            n_ccnt   = '0;
        end
    end

    // Pack the candidates in emission order into at most two queue writes.
    always_comb begin
        tok_a = '{kind: a_kind, start_pos: FIELD_W'(a_start), end_pos: FIELD_W'(a_end),
                  literal_index: a_lit, run_last: 1'b0, formula_done: i_s_tlast};
        tok_b = '{kind: b_kind, start_pos: FIELD_W'(r_pos), end_pos: FIELD_W'(end1),
                  literal_index: '0, run_last: 1'b0, formula_done: i_s_tlast};
        tok_f = '{kind: f_kind, start_pos: FIELD_W'(f_start), end_pos: FIELD_W'(end1),
                  literal_index: f_lit, run_last: 1'b0, formula_done: i_s_tlast};
        tok0 = tok_f;
        tok1 = tok_f;
        if (a_vld) begin
            tok0 = tok_a;
            tok1 = b_vld ? tok_b : tok_f;
        end else if (b_vld) begin
            tok0 = tok_b;
        end
        wr_n = 2'({1'b0, a_vld} + {1'b0, b_vld} + {1'b0, f_vld});
        if (wr_n == 2'd2) begin
            tok1.run_last = 1'b1;
        end else begin
            tok0.run_last = 1'b1;
        end
        if (!in_fire) begin
            wr_n = 2'd0;
        end
    end

    assign n_wr_ptr = r_wr_ptr + wr_n;
    assign n_rd_ptr = r_rd_ptr + {1'b0, out_fire};
    assign n_count  = r_count + {1'b0, wr_n} - {2'b00, out_fire};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FIRST;
            r_node   <= NODE_ROOT;
            r_tstart <= '0;
            r_pos    <= '0;
            r_ncnt   <= '0;
            r_ccnt   <= '0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_mode   <= n_mode;
                r_node   <= n_node;
                r_tstart <= n_tstart;
                r_pos    <= n_pos;
                r_ncnt   <= n_ncnt;
                r_ccnt   <= n_ccnt;
            end
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= tok0;
        end
        if (wr_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= tok1;
        end
    end

    assign o_m_tdata = {r_fifo[r_rd_ptr].literal_index, r_fifo[r_rd_ptr].end_pos,
                        r_fifo[r_rd_ptr].start_pos};
    assign o_m_tuser = {2'b00, r_fifo[r_rd_ptr].formula_done, r_fifo[r_rd_ptr].kind};
    assign o_m_tlast = r_fifo[r_rd_ptr].run_last;

endmodule
